// ===== rtl/bmmd_pkg.sv =====
package bmmd_pkg;

  // RAM sizes in bytes
  localparam int CHIP_BYTES = 524288;
  localparam int SLOW_BYTES = 524288;

  localparam int SEG_BYTES = 65536;
  localparam int CHIP_SEGS = CHIP_BYTES / SEG_BYTES;
  localparam int SLOW_SEGS = SLOW_BYTES / SEG_BYTES;
  localparam int CHIP_AW   = $clog2(CHIP_BYTES);
  localparam int SLOW_AW   = $clog2(SLOW_BYTES);
  localparam int MAX_BYTES = (CHIP_BYTES > SLOW_BYTES) ? CHIP_BYTES : SLOW_BYTES;
  localparam int CLR_AW    = $clog2(MAX_BYTES);

  localparam int ADDR_W = 24;
  localparam int OFFS_W = 21;

  // Segment map
  localparam logic [7:0] SEG_OVL_END   = 8'h04;
  localparam logic [7:0] SEG_CHIP_END  = 8'h20;
  localparam logic [7:0] SEG_SLOW_BASE = 8'hC0;
  localparam logic [7:0] SEG_SLOW_SPAN = 8'h18;
  localparam logic [7:0] SEG_CUSTOM_HI = 8'hDF;
  localparam logic [7:0] SEG_CIA       = 8'hBF;
  localparam logic [7:0] SEG_AUTO      = 8'hE8;
  localparam logic [7:0] SEG_ROM_BASE  = 8'hFC;
  localparam logic [7:0] CHIP_SEGS8    = 8'(CHIP_SEGS);
  localparam logic [7:0] SLOW_SEGS8    = 8'(SLOW_SEGS);

  // Access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Configuration registers
  localparam int          CFG_AW           = 2;
  localparam logic [1:0]  CFG_BOOT_OVERLAY = 2'd0;

  typedef enum logic [2:0] {
    RG_CHIP   = 3'd0,
    RG_SLOW   = 3'd1,
    RG_ROM    = 3'd2,
    RG_CUSTOM = 3'd3,
    RG_CIA    = 3'd4,
    RG_AUTO   = 3'd5,
    RG_NONE   = 3'd6
  } region_t;

  typedef struct packed {
    region_t             region;
    logic [OFFS_W-1:0]   offset;
  } dec_t;

  // One byte request from the front to the back
  typedef struct packed {
    region_t             region;
    logic [ADDR_W-1:0]   byte_address;
    logic [OFFS_W-1:0]   local_offset;
    logic [7:0]          write_byte;
    logic                is_write;
    logic                misaligned;
    logic                last_byte;
  } req_t;

  function automatic dec_t decode_byte(logic [ADDR_W-1:0] addr, logic overlay);
    logic [7:0]  seg;
    logic [15:0] low;
    logic [7:0]  s;
    dec_t        d;
    seg      = addr[23:16];
    low      = addr[15:0];
    d.region = RG_NONE;
    d.offset = '0;
    if (overlay && seg < SEG_OVL_END) begin
      d.region = RG_ROM;
      d.offset = addr[OFFS_W-1:0];
    end else if (seg < SEG_CHIP_END) begin
      // mirror chip RAM across the rest of its window
      s        = (seg < CHIP_SEGS8) ? seg : (seg & (CHIP_SEGS8 - 8'd1));
      d.region = RG_CHIP;
      d.offset = {s[4:0], low};
    end else if (seg >= SEG_SLOW_BASE && seg < SEG_SLOW_BASE + SEG_SLOW_SPAN) begin
      s = seg - SEG_SLOW_BASE;
      if (s < SLOW_SEGS8) begin
        d.region = RG_SLOW;
        d.offset = {s[4:0], low};
      end else begin
        d.region = RG_CUSTOM;
      end
    end else if (seg == SEG_CUSTOM_HI) begin
      d.region = RG_CUSTOM;
    end else if (seg == SEG_CIA) begin
      d.region = RG_CIA;
    end else if (seg == SEG_AUTO) begin
      d.region = RG_AUTO;
    end else if (seg >= SEG_ROM_BASE) begin
      s        = seg - SEG_ROM_BASE;
      d.region = RG_ROM;
      d.offset = {s[4:0], low};
    end
    return d;
  endfunction

endpackage

// ===== rtl/bmmd_front.sv =====
module bmmd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bmmd_pkg::ADDR_W-1:0] in_address,
  input  logic                      in_func,
  input  logic [1:0]                in_access_size,
  input  logic [31:0]               in_write_value,
  input  logic                      overlay,
  input  logic                      clearing,
  input  logic                      q_full,
  output logic                      push,
  output bmmd_pkg::req_t            push_req
);
  import bmmd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic              wr_r;
  logic [31:0]       wval_r;
  logic              mis_r;
  logic [1:0]        k_r, k_nxt;
  logic [1:0]        last_r;
  logic              accept;
  logic              push_last;
  logic [1:0]        sel;
  logic [7:0]        wb;
  logic [ADDR_W-1:0] ba;
  dec_t              dec;

  assign push      = busy_r && !q_full;
  assign push_last = (k_r == last_r);
  // take the next access on the edge that sends the final byte of this one
  assign in_stall  = clearing || (busy_r && !(push && push_last));
  assign accept    = in_valid && !in_stall;

  assign ba  = addr_r + ADDR_W'(k_r);
  assign sel = last_r - k_r;
  assign dec = decode_byte(ba, overlay);

  always_comb begin
    case (sel)
      2'd0:    wb = wval_r[7:0];
      2'd1:    wb = wval_r[15:8];
      2'd2:    wb = wval_r[23:16];
      default: wb = wval_r[31:24];
    endcase
    push_req.region       = dec.region;
    push_req.byte_address = ba;
    push_req.local_offset = dec.offset;
    push_req.write_byte   = wr_r ? wb : 8'd0;
    push_req.is_write     = wr_r;
    push_req.misaligned   = mis_r;
    push_req.last_byte    = push_last;
  end

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (push) begin
      k_nxt = k_r + 2'd1;
      if (push_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      k_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_address;
      wr_r   <= in_func;
      wval_r <= in_write_value;
      mis_r  <= (in_access_size != SIZE_BYTE) && in_address[0];
      case (in_access_size)
        SIZE_BYTE: last_r <= 2'd0;
        SIZE_WORD: last_r <= 2'd1;
        default:   last_r <= 2'd3;
      endcase
    end
  end

endmodule

// ===== rtl/bmmd_queue.sv =====
module bmmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bmmd_pkg::req_t  push_req,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output bmmd_pkg::req_t  head
);
  import bmmd_pkg::*;

  req_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_req;
    end
  end

endmodule

// ===== rtl/bmmd_back.sv =====
module bmmd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  bmmd_pkg::req_t                head,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_region,
  output logic [bmmd_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [bmmd_pkg::OFFS_W-1:0]   out_local_offset,
  output logic [7:0]                    out_read_byte,
  output logic [7:0]                    out_write_byte,
  output logic                          out_is_write,
  output logic                          out_misaligned,
  output logic                          out_last_byte
);
  import bmmd_pkg::*;

  logic [7:0] chip_mem [CHIP_BYTES];
  logic [7:0] slow_mem [SLOW_BYTES];

  logic              clearing_r;
  logic [CLR_AW-1:0] clr_r;
  logic              valid_r, valid_nxt;
  req_t              req_r;
  logic              rd_chip_r, rd_slow_r;
  logic [7:0]        chip_rd_r, slow_rd_r;

  logic              chip_hit, slow_hit;
  logic              chip_we, chip_re, slow_we, slow_re;
  logic [CHIP_AW-1:0] chip_addr;
  logic [SLOW_AW-1:0] slow_addr;
  logic [7:0]        chip_wd, slow_wd;

  assign clearing = clearing_r;
  assign pop      = !q_empty && !clearing_r && (!valid_r || !out_stall);

  assign chip_hit = pop && head.region == RG_CHIP
                    && {11'd0, head.local_offset} < 32'(CHIP_BYTES);
  assign slow_hit = pop && head.region == RG_SLOW
                    && {11'd0, head.local_offset} < 32'(SLOW_BYTES);

  // the reset sweep owns both RAM ports until it finishes
  assign chip_we   = clearing_r ? ({{(32-CLR_AW){1'b0}}, clr_r} < 32'(CHIP_BYTES))
                                : (chip_hit && head.is_write);
  assign slow_we   = clearing_r ? ({{(32-CLR_AW){1'b0}}, clr_r} < 32'(SLOW_BYTES))
                                : (slow_hit && head.is_write);
  assign chip_re   = chip_hit && !head.is_write;
  assign slow_re   = slow_hit && !head.is_write;
  assign chip_addr = clearing_r ? clr_r[CHIP_AW-1:0] : head.local_offset[CHIP_AW-1:0];
  assign slow_addr = clearing_r ? clr_r[SLOW_AW-1:0] : head.local_offset[SLOW_AW-1:0];
  assign chip_wd   = clearing_r ? 8'd0 : head.write_byte;
  assign slow_wd   = clearing_r ? 8'd0 : head.write_byte;

  always_ff @(posedge clk) begin
    if (chip_we) begin
      chip_mem[chip_addr] <= chip_wd;
    end
    if (chip_re) begin
      chip_rd_r <= chip_mem[chip_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (slow_we) begin
      slow_mem[slow_addr] <= slow_wd;
    end
    if (slow_re) begin
      slow_rd_r <= slow_mem[slow_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      if (clr_r == CLR_AW'(MAX_BYTES - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold the request and the read flags while the result is stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      req_r     <= head;
      rd_chip_r <= chip_re;
      rd_slow_r <= slow_re;
    end
  end

  assign out_valid        = valid_r;
  assign out_region       = req_r.region;
  assign out_byte_address = req_r.byte_address;
  assign out_local_offset = req_r.local_offset;
  assign out_read_byte    = rd_chip_r ? chip_rd_r : (rd_slow_r ? slow_rd_r : 8'd0);
  assign out_write_byte   = req_r.write_byte;
  assign out_is_write     = req_r.is_write;
  assign out_misaligned   = req_r.misaligned;
  assign out_last_byte    = req_r.last_byte;

endmodule

// ===== rtl/bus_memory_map_decoder_top.sv =====
// Each byte goes from the front registers through a queue slot to the back result register.
// Throughput: the front sends one byte a cycle while the queue is not full; a request is
// 1, 2 or 4 bytes (byte, word, long); the next is taken on the edge of the final byte.
// Reset: boot_overlay goes to 1 and both RAMs are swept to zero one byte per cycle,
// max(CHIP_BYTES, SLOW_BYTES) = 524288 bytes, with in_stall high; config writes still work.
module bus_memory_map_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bmmd_pkg::ADDR_W-1:0]   in_address,
  input  logic                          in_func,
  input  logic [1:0]                    in_access_size,
  input  logic [31:0]                   in_write_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_region,
  output logic [bmmd_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [bmmd_pkg::OFFS_W-1:0]   out_local_offset,
  output logic [7:0]                    out_read_byte,
  output logic [7:0]                    out_write_byte,
  output logic                          out_is_write,
  output logic                          out_misaligned,
  output logic                          out_last_byte,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmmd_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bmmd_pkg::*;

  logic   overlay_r;
  logic   clearing;
  logic   q_full, q_empty;
  logic   push, pop;
  req_t   push_req;
  req_t   head;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_BOOT_OVERLAY) ? {31'd0, overlay_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overlay_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == CFG_BOOT_OVERLAY) begin
      overlay_r <= pwdata[0];
    end
  end

  bmmd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .in_func        (in_func),
    .in_access_size (in_access_size),
    .in_write_value (in_write_value),
    .overlay        (overlay_r),
    .clearing       (clearing),
    .q_full         (q_full),
    .push           (push),
    .push_req       (push_req)
  );

  bmmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  bmmd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region       (out_region),
    .out_byte_address (out_byte_address),
    .out_local_offset (out_local_offset),
    .out_read_byte    (out_read_byte),
    .out_write_byte   (out_write_byte),
    .out_is_write     (out_is_write),
    .out_misaligned   (out_misaligned),
    .out_last_byte    (out_last_byte)
  );

endmodule

// ===== rtl/bmmd_checker.sv =====
module bmmd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [2:0]                    out_region,
  input logic [bmmd_pkg::ADDR_W-1:0]   out_byte_address,
  input logic [bmmd_pkg::OFFS_W-1:0]   out_local_offset,
  input logic [7:0]                    out_read_byte,
  input logic [7:0]                    out_write_byte,
  input logic                          out_is_write
);
  import bmmd_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_address)
      && $stable(out_write_byte))
    else $error("result changed while stalled");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_write || (out_region != RG_CHIP && out_region != RG_SLOW))
      |-> out_read_byte == 8'd0)
    else $error("read data outside a RAM read");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_write |-> out_write_byte == 8'd0)
    else $error("write byte on a read");

  a_chip_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == RG_CHIP |-> out_byte_address[23:21] == 3'd0)
    else $error("chip region outside its window");

  a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_region == RG_CUSTOM || out_region == RG_CIA
      || out_region == RG_AUTO || out_region == RG_NONE) |-> out_local_offset == '0)
    else $error("offset on a device region");

endmodule

bind bus_memory_map_decoder_top bmmd_checker u_bmmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_region       (out_region),
  .out_byte_address (out_byte_address),
  .out_local_offset (out_local_offset),
  .out_read_byte    (out_read_byte),
  .out_write_byte   (out_write_byte),
  .out_is_write     (out_is_write)
);

// ===== tb/sv/bus_memory_map_decoder_top_test.sv =====
`timescale 1ns / 1ps

module bus_memory_map_decoder_top_test;
  import bmmd_pkg::*;

  localparam logic       FN_READ        = 1'b0;
  localparam logic       FN_WRITE       = 1'b1;
  localparam logic [1:0] SIZE_LONG      = 2'd2;
  localparam logic [1:0] SIZE_RSVD      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1600000;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         RANDOM_PER_PHASE = 115;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              func;
    logic [1:0]        size;
    logic [31:0]       wval;
  } bus_req_t;

  typedef struct {
    region_t           region;
    logic [ADDR_W-1:0] byte_address;
    logic [OFFS_W-1:0] local_offset;
    logic [7:0]        read_byte;
    logic [7:0]        write_byte;
    logic              is_write;
    logic              misaligned;
    logic              last_byte;
  } byte_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ADDR_W-1:0]   in_address = '0;
  logic                in_func = FN_READ;
  logic [1:0]          in_access_size = SIZE_BYTE;
  logic [31:0]         in_write_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          out_region;
  logic [ADDR_W-1:0]   out_byte_address;
  logic [OFFS_W-1:0]   out_local_offset;
  logic [7:0]          out_read_byte;
  logic [7:0]          out_write_byte;
  logic                out_is_write;
  logic                out_misaligned;
  logic                out_last_byte;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  bus_memory_map_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .in_func          (in_func),
    .in_access_size   (in_access_size),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region       (out_region),
    .out_byte_address (out_byte_address),
    .out_local_offset (out_local_offset),
    .out_read_byte    (out_read_byte),
    .out_write_byte   (out_write_byte),
    .out_is_write     (out_is_write),
    .out_misaligned   (out_misaligned),
    .out_last_byte    (out_last_byte),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [7:0]        chip_image [int];
  logic [7:0]        slow_image [int];
  logic              overlay_on = 1'b1;
  byte_result_t      expected_bytes [$];

  bus_req_t          pending_reqs [$];
  logic [ADDR_W-1:0] recent_writes [$];
  bus_req_t          cur_req;
  byte_result_t      head;
  int                queued_reqs = 0;
  int                accepted_reqs = 0;
  int                results_seen = 0;
  int                mismatches = 0;
  int                quiet_cycles = 0;
  int                req_gap = 0;
  int                hold_left = 0;
  logic              req_taken = 1'b0;
  logic              byte_taken = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Split one bus access into byte results and update the RAM images.
  task automatic predict_access(input logic [ADDR_W-1:0] addr, input logic func,
                                input logic [1:0] size, input logic [31:0] wval);
    int                nbytes;
    int                k;
    int                seg;
    logic [ADDR_W-1:0] ba;
    byte_result_t      r;
    nbytes = (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
    for (k = 0; k < nbytes; k++) begin
      ba  = addr + ADDR_W'(k);
      seg = int'(ba[23:16]);
      r.region       = RG_NONE;
      r.local_offset = '0;
      if (overlay_on && seg < int'(SEG_OVL_END)) begin
        r.region       = RG_ROM;
        r.local_offset = ba[OFFS_W-1:0];
      end else if (seg < int'(SEG_CHIP_END)) begin
        r.region       = RG_CHIP;
        r.local_offset = OFFS_W'((seg % CHIP_SEGS) * SEG_BYTES + int'(ba[15:0]));
      end else if (seg >= int'(SEG_SLOW_BASE)
                   && seg < int'(SEG_SLOW_BASE) + int'(SEG_SLOW_SPAN)) begin
        if (seg - int'(SEG_SLOW_BASE) < SLOW_SEGS) begin
          r.region       = RG_SLOW;
          r.local_offset = OFFS_W'((seg - int'(SEG_SLOW_BASE)) * SEG_BYTES + int'(ba[15:0]));
        end else begin
          r.region = RG_CUSTOM;
        end
      end else if (seg == int'(SEG_CUSTOM_HI)) begin
        r.region = RG_CUSTOM;
      end else if (seg == int'(SEG_CIA)) begin
        r.region = RG_CIA;
      end else if (seg == int'(SEG_AUTO)) begin
        r.region = RG_AUTO;
      end else if (seg >= int'(SEG_ROM_BASE)) begin
        r.region       = RG_ROM;
        r.local_offset = OFFS_W'((seg - int'(SEG_ROM_BASE)) * SEG_BYTES + int'(ba[15:0]));
      end
      r.byte_address = ba;
      r.read_byte    = 8'h00;
      r.write_byte   = (func == FN_WRITE) ? 8'(wval >> (8 * (nbytes - 1 - k))) : 8'h00;
      r.is_write     = func;
      r.misaligned   = (size != SIZE_BYTE) && addr[0];
      r.last_byte    = (k == nbytes - 1);
      if (r.region == RG_CHIP) begin
        if (func == FN_WRITE) chip_image[int'(r.local_offset)] = r.write_byte;
        else if (chip_image.exists(int'(r.local_offset)))
          r.read_byte = chip_image[int'(r.local_offset)];
      end else if (r.region == RG_SLOW) begin
        if (func == FN_WRITE) slow_image[int'(r.local_offset)] = r.write_byte;
        else if (slow_image.exists(int'(r.local_offset)))
          r.read_byte = slow_image[int'(r.local_offset)];
      end
      expected_bytes.push_back(r);
    end
  endtask

  task automatic queue_req(input logic [ADDR_W-1:0] addr, input logic func,
                           input logic [1:0] size, input logic [31:0] wval);
    bus_req_t r;
    r.addr = addr;
    r.func = func;
    r.size = size;
    r.wval = wval;
    pending_reqs.push_back(r);
    queued_reqs++;
    if (func == FN_WRITE) begin
      recent_writes.push_back(addr);
      if (recent_writes.size() > 24) void'(recent_writes.pop_front());
    end
  endtask

  task automatic queue_random(input int n);
    int                i;
    logic [7:0]        seg;
    logic [15:0]       lo;
    logic [ADDR_W-1:0] addr;
    logic              func;
    logic [1:0]        size;
    for (i = 0; i < n; i++) begin
      func = ($urandom_range(0, 1) == 1) ? FN_WRITE : FN_READ;
      case ($urandom_range(0, 19))
        0:                         size = SIZE_RSVD;
        1, 2, 3, 4, 5, 6, 7:       size = SIZE_BYTE;
        8, 9, 10, 11, 12, 13:      size = SIZE_WORD;
        default:                   size = SIZE_LONG;
      endcase
      if (recent_writes.size() != 0 && $urandom_range(0, 9) < 4) begin
        // revisit a written location, possibly through a chip RAM mirror
        addr = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        if (addr[23:21] == 3'b000) addr[20:19] = 2'($urandom);
      end else begin
        case ($urandom_range(0, 11))
          0:       seg = 8'($urandom_range(0, 3));
          1:       seg = 8'($urandom_range(4, 7));
          2:       seg = 8'($urandom_range(8, 'h1F));
          3:       seg = 8'($urandom_range('hC0, 'hC7));
          4:       seg = 8'($urandom_range('hC8, 'hD7));
          5:       seg = SEG_CUSTOM_HI;
          6:       seg = SEG_CIA;
          7:       seg = SEG_AUTO;
          8:       seg = 8'($urandom_range('hFC, 'hFF));
          9:       seg = 8'($urandom_range(0, 255));
          default: seg = 8'($urandom_range('h20, 'hBE));
        endcase
        lo = 16'($urandom);
        // land on a segment boundary now and then
        if ($urandom_range(0, 9) == 0) lo = 16'hFFFC + 16'($urandom_range(0, 3));
        addr = {seg, lo};
      end
      if (size != SIZE_BYTE && $urandom_range(0, 3) != 0) addr[0] = 1'b0;
      queue_req(addr, func, size, $urandom());
    end
  endtask

  task automatic wait_idle();
    while (accepted_reqs != queued_reqs || expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_overlay(input logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_BOOT_OVERLAY;
    pwdata  <= {31'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    overlay_on = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_gap > 0) begin
        req_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        in_valid       <= 1'b1;
        in_address     <= cur_req.addr;
        in_func        <= cur_req.func;
        in_access_size <= cur_req.size;
        in_write_value <= cur_req.wval;
        // every fourth run of 32 requests goes back to back
        req_gap = ((accepted_reqs / 32) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall
  always @(negedge clk) begin
    if (byte_taken) hold_left = ((results_seen / 32) % 4 == 1) ? 0 : $urandom_range(0, 3);
    if (!rst_n || hold_left == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      hold_left--;
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    req_taken  = rst_n && in_valid && !in_stall;
    byte_taken = rst_n && out_valid && !out_stall;
    if (req_taken) begin
      predict_access(in_address, in_func, in_access_size, in_write_value);
      accepted_reqs++;
    end
    if (byte_taken) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result at %06h", out_byte_address));
      end else begin
        head = expected_bytes.pop_front();
        if (out_region !== head.region)
          flag_mismatch($sformatf("%06h region got %0d exp %0d",
                                  head.byte_address, out_region, head.region));
        if (out_byte_address !== head.byte_address)
          flag_mismatch($sformatf("byte_address got %06h exp %06h",
                                  out_byte_address, head.byte_address));
        if (out_local_offset !== head.local_offset)
          flag_mismatch($sformatf("%06h local_offset got %06h exp %06h",
                                  head.byte_address, out_local_offset, head.local_offset));
        if (out_read_byte !== head.read_byte)
          flag_mismatch($sformatf("%06h read_byte got %02h exp %02h",
                                  head.byte_address, out_read_byte, head.read_byte));
        if (out_write_byte !== head.write_byte)
          flag_mismatch($sformatf("%06h write_byte got %02h exp %02h",
                                  head.byte_address, out_write_byte, head.write_byte));
        if (out_is_write !== head.is_write)
          flag_mismatch($sformatf("%06h is_write got %0b exp %0b",
                                  head.byte_address, out_is_write, head.is_write));
        if (out_misaligned !== head.misaligned)
          flag_mismatch($sformatf("%06h misaligned got %0b exp %0b",
                                  head.byte_address, out_misaligned, head.misaligned));
        if (out_last_byte !== head.last_byte)
          flag_mismatch($sformatf("%06h last_byte got %0b exp %0b",
                                  head.byte_address, out_last_byte, head.last_byte));
      end
    end
    if (req_taken || byte_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Overlay on: ROM over the low segments, writes there dropped
    write_overlay(1'b1);
    queue_req(24'h000000, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'h000000, FN_WRITE, SIZE_LONG, 32'hA5A5A5A5);
    queue_req(24'h000010, FN_WRITE, SIZE_LONG, 32'hFFFFFFFF);
    queue_req(24'h03FFFE, FN_WRITE, SIZE_WORD, 32'h0000BEEF);
    queue_req(24'h040000, FN_READ,  SIZE_BYTE, 32'hFFFFFFFF);
    queue_req(24'h07FFFC, FN_WRITE, SIZE_LONG, 32'h11223344);
    queue_req(24'h0FFFFC, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'hC7FFFF, FN_WRITE, SIZE_WORD, 32'h0000C3D4);
    queue_req(24'hC7FFFF, FN_READ,  SIZE_WORD, 32'h0);
    queue_req(24'hC80000, FN_READ,  SIZE_BYTE, 32'h0);
    queue_req(24'hDFF000, FN_WRITE, SIZE_BYTE, 32'h000000FF);
    queue_req(24'hBF0001, FN_READ,  SIZE_BYTE, 32'h0);
    queue_req(24'hE80000, FN_WRITE, SIZE_WORD, 32'h00001234);
    queue_req(24'h200000, FN_WRITE, SIZE_BYTE, 32'h00000077);
    queue_req(24'h200000, FN_READ,  SIZE_BYTE, 32'h0);
    queue_req(24'hFFFFFE, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'hFC0001, FN_WRITE, SIZE_WORD, 32'h0000ABCD);
    queue_req(24'h000100, FN_READ,  SIZE_RSVD, 32'h0);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    // Overlay off: low segments are plain chip RAM
    write_overlay(1'b0);
    queue_req(24'h000010, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'h000000, FN_WRITE, SIZE_LONG, 32'hDEADBEEF);
    queue_req(24'h180000, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'hFFFFFE, FN_READ,  SIZE_LONG, 32'h0);
    queue_req(24'h03FFFF, FN_WRITE, SIZE_BYTE, 32'h0000005A);
    queue_req(24'h03FFFF, FN_READ,  SIZE_BYTE, 32'h0);
    queue_req(24'h000201, FN_WRITE, SIZE_RSVD, 32'h87654321);
    queue_req(24'h000201, FN_READ,  SIZE_LONG, 32'h0);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    write_overlay(1'b1);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    write_overlay(1'b0);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
